>>> rtl/rpe_pkg.sv
// Shared types and constants for the RGB pixel effect unit.
// No dependencies; imported by rpe_color_math and rgb_pixel_effect_unit.
package rpe_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } rgb_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } rgb_out_t;

  // Effect codes; codes 10..15 behave as copy
  typedef enum logic [3:0] {
    FX_COPY      = 4'd0,
    FX_HALVE     = 4'd1,
    FX_INVERT    = 4'd2,
    FX_GRAY      = 4'd3,
    FX_POSTER    = 4'd4,
    FX_EMBOSS    = 4'd5,
    FX_SEPIA     = 4'd6,
    FX_SOLARIZE  = 4'd7,
    FX_THRESHOLD = 4'd8,
    FX_CONTRAST  = 4'd9
  } fx_mode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SOLARIZE = 2'd1;
  localparam logic [1:0] REG_BINARY   = 2'd2;

  localparam logic [3:0] MODE_RST     = 4'd0;
  localparam logic [7:0] SOLARIZE_RST = 8'd128;
  localparam logic [7:0] BINARY_RST   = 8'd160;

  localparam logic [7:0] POSTER_MASK  = 8'hE0;
  localparam logic [7:0] EMBOSS_BIAS  = 8'd128;

  // floor(x/3) for x <= 765 as (x * 683) >> 11
  localparam logic [19:0] DIV3_MUL    = 20'd683;
  localparam int          DIV3_SHIFT  = 11;

  // Sepia weights, row per output channel
  localparam logic [15:0] SEP_RR = 16'd105;
  localparam logic [15:0] SEP_RG = 16'd218;
  localparam logic [15:0] SEP_RB = 16'd42;
  localparam logic [15:0] SEP_GR = 16'd54;
  localparam logic [15:0] SEP_GG = 16'd183;
  localparam logic [15:0] SEP_GB = 16'd18;
  localparam logic [15:0] SEP_BR = 16'd13;
  localparam logic [15:0] SEP_BG = 16'd66;
  localparam logic [15:0] SEP_BB = 16'd203;

  // What the arithmetic stages hand to the selection stage
  typedef struct packed {
    rgb_in_t    pix;
    logic [7:0] avg;
    rgb_in_t    sepia;
  } rpe_math_t;

endpackage

>>> rtl/rpe_color_math.sv
// Two pipeline stages: channel sum and sepia products, then average and sepia sums.
// Depends on rpe_pkg.
module rpe_color_math (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  rpe_pkg::rgb_in_t in_pix,
  output logic             out_vld,
  output rpe_pkg::rpe_math_t out_data
);
  import rpe_pkg::*;

  // stage 1
  logic        vld1_r;
  rgb_in_t     pix1_r;
  logic [9:0]  sum1_r;
  logic [15:0] p_rr_r, p_rg_r, p_rb_r;
  logic [15:0] p_gr_r, p_gg_r, p_gb_r;
  logic [15:0] p_br_r, p_bg_r, p_bb_r;

  // stage 2
  logic       vld2_r;
  rpe_math_t  data2_r;

  logic [19:0] avg_prod;
  logic [17:0] sep_r_sum, sep_g_sum, sep_b_sum;
  rpe_math_t   data2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r <= in_pix;
    sum1_r <= {2'b00, in_pix.in_red} + {2'b00, in_pix.in_green} + {2'b00, in_pix.in_blue};
    p_rr_r <= {8'd0, in_pix.in_red}   * SEP_RR;
    p_rg_r <= {8'd0, in_pix.in_green} * SEP_RG;
    p_rb_r <= {8'd0, in_pix.in_blue}  * SEP_RB;
    p_gr_r <= {8'd0, in_pix.in_red}   * SEP_GR;
    p_gg_r <= {8'd0, in_pix.in_green} * SEP_GG;
    p_gb_r <= {8'd0, in_pix.in_blue}  * SEP_GB;
    p_br_r <= {8'd0, in_pix.in_red}   * SEP_BR;
    p_bg_r <= {8'd0, in_pix.in_green} * SEP_BG;
    p_bb_r <= {8'd0, in_pix.in_blue}  * SEP_BB;
  end

  always_comb begin
    avg_prod  = {10'd0, sum1_r} * DIV3_MUL;
    sep_r_sum = {2'b00, p_rr_r} + {2'b00, p_rg_r} + {2'b00, p_rb_r};
    sep_g_sum = {2'b00, p_gr_r} + {2'b00, p_gg_r} + {2'b00, p_gb_r};
    sep_b_sum = {2'b00, p_br_r} + {2'b00, p_bg_r} + {2'b00, p_bb_r};

    data2_nxt.pix             = pix1_r;
    data2_nxt.avg             = avg_prod[DIV3_SHIFT +: 8];
    // >> 8 then keep low byte
    data2_nxt.sepia.in_red    = sep_r_sum[15:8];
    data2_nxt.sepia.in_green  = sep_g_sum[15:8];
    data2_nxt.sepia.in_blue   = sep_b_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    data2_r <= data2_nxt;
  end

  assign out_vld  = vld2_r;
  assign out_data = data2_r;

endmodule

>>> rtl/rgb_pixel_effect_unit.sv
// Top level of the RGB pixel effect unit: config registers, effect select, output register.
// Depends on rpe_pkg and rpe_color_math.
//
//  channel   ports                                   handshake
//  input     start, busy, in_pixel                   transfer when start & !busy
//  result    out_valid, out_pixel                    one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   transfer when valid & ready
//
// One pixel per cycle; each result passes in order through the three register stages
// (sum/products, average/sepia sums, select) after its transfer in.
// busy is never raised and cfg_ready is always high.
// Reset (rst_n low, synchronous) clears the valid bits and restores register defaults.
module rgb_pixel_effect_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rpe_pkg::rgb_in_t  in_pixel,
  output logic              out_valid,
  output rpe_pkg::rgb_out_t out_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import rpe_pkg::*;

  logic [3:0] mode_r;
  logic [7:0] solar_lvl_r;
  logic [7:0] bin_lvl_r;

  logic       in_xfer;
  logic       cfg_xfer;
  logic       math_vld;
  rpe_math_t  math;
  logic       out_valid_r;
  rgb_out_t   out_pixel_r;
  rgb_out_t   out_pixel_nxt;

  logic [7:0] r, g, b, avg, thr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start & ~busy;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RST;
      solar_lvl_r <= SOLARIZE_RST;
      bin_lvl_r   <= BINARY_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_MODE:     mode_r      <= cfg_data[3:0];
        REG_SOLARIZE: solar_lvl_r <= cfg_data;
        REG_BINARY:   bin_lvl_r   <= cfg_data;
        default: ;  // unmapped index ignored
      endcase
    end
  end

  rpe_color_math u_math (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_xfer),
    .in_pix   (in_pixel),
    .out_vld  (math_vld),
    .out_data (math)
  );

  always_comb begin
    r   = math.pix.in_red;
    g   = math.pix.in_green;
    b   = math.pix.in_blue;
    avg = math.avg;
    thr = (avg > bin_lvl_r) ? 8'hFF : 8'h00;

    out_pixel_nxt.out_red   = r;
    out_pixel_nxt.out_green = g;
    out_pixel_nxt.out_blue  = b;

    case (mode_r)
      FX_HALVE: begin
        out_pixel_nxt.out_red   = {1'b0, r[7:1]};
        out_pixel_nxt.out_green = {1'b0, g[7:1]};
        out_pixel_nxt.out_blue  = {1'b0, b[7:1]};
      end
      FX_INVERT: begin
        out_pixel_nxt.out_red   = ~r;
        out_pixel_nxt.out_green = ~g;
        out_pixel_nxt.out_blue  = ~b;
      end
      FX_GRAY: begin
        out_pixel_nxt.out_red   = avg;
        out_pixel_nxt.out_green = avg;
        out_pixel_nxt.out_blue  = avg;
      end
      FX_POSTER: begin
        out_pixel_nxt.out_red   = r & POSTER_MASK;
        out_pixel_nxt.out_green = g & POSTER_MASK;
        out_pixel_nxt.out_blue  = b & POSTER_MASK;
      end
      FX_EMBOSS: begin
        // mod-256 arithmetic, wraps
        out_pixel_nxt.out_red   = r - g + EMBOSS_BIAS;
        out_pixel_nxt.out_green = g - b + EMBOSS_BIAS;
        out_pixel_nxt.out_blue  = b - g + EMBOSS_BIAS;
      end
      FX_SEPIA: begin
        out_pixel_nxt.out_red   = math.sepia.in_red;
        out_pixel_nxt.out_green = math.sepia.in_green;
        out_pixel_nxt.out_blue  = math.sepia.in_blue;
      end
      FX_SOLARIZE: begin
        out_pixel_nxt.out_red   = (r > solar_lvl_r) ? ~r : r;
        out_pixel_nxt.out_green = (g > solar_lvl_r) ? ~g : g;
        out_pixel_nxt.out_blue  = (b > solar_lvl_r) ? ~b : b;
      end
      FX_THRESHOLD: begin
        out_pixel_nxt.out_red   = thr;
        out_pixel_nxt.out_green = thr;
        out_pixel_nxt.out_blue  = thr;
      end
      FX_CONTRAST: begin
        // 3c - 2avg, low byte only
        out_pixel_nxt.out_red   = r + {r[6:0], 1'b0} - {avg[6:0], 1'b0};
        out_pixel_nxt.out_green = g + {g[6:0], 1'b0} - {avg[6:0], 1'b0};
        out_pixel_nxt.out_blue  = b + {b[6:0], 1'b0} - {avg[6:0], 1'b0};
      end
      default: ;  // copy, and unused codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= math_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule
